// File: rtl/core/cfr_pkg.sv
// cfr_pkg: shared types and constants of the checksummed frame receiver
// no dependencies; used by the interfaces, controller, datapath and top level

package cfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_A_W = 1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 6'd32;

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_START_BYTE = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_HUNT = 6'b000001,
    ST_TYPE = 6'b000010,
    ST_LEN  = 6'b000100,
    ST_BODY = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic cap_type;
    logic cap_len;
    logic wr_body;
    logic chk_sum;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_start;
    logic len_zero;
    logic len_over;
    logic body_done;
    logic sum_match;
    logic emit_done;
  } sts_t;

endpackage

// File: rtl/core/cfr_if.sv
// cfr interfaces: received byte channel, result channel and config write channel
// depends on cfr_pkg for field widths

interface cfr_rx_if;
  logic                         valid;
  logic                         ready;
  logic [cfr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if;
  logic                         valid;
  logic                         ready;
  logic [cfr_pkg::BYTE_W-1:0]   frame_type;
  logic [cfr_pkg::LEN_W-1:0]    frame_length;
  logic [cfr_pkg::IDX_W-1:0]    byte_index;
  logic [cfr_pkg::BYTE_W-1:0]   payload_byte;
  logic                         has_payload;
  logic                         last_of_frame;

  modport source (output valid, output frame_type, output frame_length,
                  output byte_index, output payload_byte, output has_payload,
                  output last_of_frame, input ready);
  modport sink   (input valid, input frame_type, input frame_length,
                  input byte_index, input payload_byte, input has_payload,
                  input last_of_frame, output ready);
endinterface

interface cfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cfr_pkg::CFG_A_W-1:0]  index;
  logic [cfr_pkg::BYTE_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/checksummed_frame_receiver.sv
// checksummed_frame_receiver: top level, joins controller, datapath and channels
// depends on cfr_pkg, cfr_if, cfr_ctrl and cfr_dp
//
//   port    dir   kind          contents
//   rx_i    in    valid/ready   rx_byte
//   res_o   out   valid/ready   frame_type, frame_length, byte_index, payload_byte,
//                               has_payload, last_of_frame
//   cfg_i   in    valid/ready   index (0 start_byte, 1 max_length), data; always ready
//
// parsing takes one received byte per cycle
// after a good checksum rx_i is held for the whole readout of max(length, 1) results,
// one result per cycle while res_o takes them, through the single read port of the payload memory
// readout stalls with res_o; a new byte is taken while the last result waits
// reset is immediate, no memory clearing pass

module checksummed_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfr_rx_if.sink     rx_i,
  cfr_res_if.source  res_o,
  cfr_cfg_if.sink    cfg_i
);

  cfr_pkg::cmd_t cmd;
  cfr_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  cfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_i.rx_byte),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .res_ready_i     (res_o.ready),
    .res_valid_o     (res_o.valid),
    .frame_type_o    (res_o.frame_type),
    .frame_length_o  (res_o.frame_length),
    .byte_index_o    (res_o.byte_index),
    .payload_byte_o  (res_o.payload_byte),
    .has_payload_o   (res_o.has_payload),
    .last_of_frame_o (res_o.last_of_frame)
  );

endmodule

// File: rtl/core/cfr_ctrl.sv
// cfr_ctrl: frame parsing state machine, issues commands to the datapath
// depends on cfr_pkg

module cfr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cfr_pkg::sts_t   sts_i,
  output cfr_pkg::cmd_t   cmd_o
);

  cfr_pkg::state_e state_q, state_d;
  logic            fire;

  assign in_ready_o = (state_q != cfr_pkg::ST_EMIT);
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.cap_type = fire && (state_q == cfr_pkg::ST_TYPE);
    cmd_o.cap_len  = fire && (state_q == cfr_pkg::ST_LEN);
    cmd_o.wr_body  = fire && (state_q == cfr_pkg::ST_BODY);
    cmd_o.chk_sum  = fire && (state_q == cfr_pkg::ST_SUM);
    cmd_o.emit     = (state_q == cfr_pkg::ST_EMIT);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfr_pkg::ST_HUNT: begin
        if (fire && sts_i.is_start) state_d = cfr_pkg::ST_TYPE;
      end
      cfr_pkg::ST_TYPE: begin
        if (fire) state_d = cfr_pkg::ST_LEN;
      end
      cfr_pkg::ST_LEN: begin
        if (fire) begin
          if (sts_i.len_zero)      state_d = cfr_pkg::ST_SUM;
          else if (sts_i.len_over) state_d = cfr_pkg::ST_HUNT;
          else                     state_d = cfr_pkg::ST_BODY;
        end
      end
      cfr_pkg::ST_BODY: begin
        if (fire && sts_i.body_done) state_d = cfr_pkg::ST_SUM;
      end
      cfr_pkg::ST_SUM: begin
        if (fire) state_d = sts_i.sum_match ? cfr_pkg::ST_EMIT : cfr_pkg::ST_HUNT;
      end
      cfr_pkg::ST_EMIT: begin
        if (sts_i.emit_done) state_d = cfr_pkg::ST_HUNT;
      end
      default: state_d = cfr_pkg::ST_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfr_pkg::ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // readout always ends back in the hunt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.emit_done |=> (state_q == cfr_pkg::ST_HUNT))
    else $error("readout did not return to hunt");

  // a good checksum always starts readout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.chk_sum && sts_i.sum_match) |=> (state_q == cfr_pkg::ST_EMIT))
    else $error("good frame not emitted");

endmodule

// File: rtl/core/cfr_dp.sv
// cfr_dp: config registers, frame header and sum registers, payload memory, result register
// depends on cfr_pkg

module cfr_dp #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cfr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  cfr_pkg::cmd_t                 cmd_i,
  output cfr_pkg::sts_t                 sts_o,
  input  logic                          cfg_valid_i,
  input  logic [cfr_pkg::CFG_A_W-1:0]   cfg_index_i,
  input  logic [cfr_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic [cfr_pkg::BYTE_W-1:0]    frame_type_o,
  output logic [cfr_pkg::LEN_W-1:0]     frame_length_o,
  output logic [cfr_pkg::IDX_W-1:0]     byte_index_o,
  output logic [cfr_pkg::BYTE_W-1:0]    payload_byte_o,
  output logic                          has_payload_o,
  output logic                          last_of_frame_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned LW = cfr_pkg::LEN_W;
  localparam int unsigned BW = cfr_pkg::BYTE_W;

  logic [BW-1:0] start_q;
  logic [LW-1:0] max_len_q;
  logic [BW-1:0] type_q;
  logic [LW-1:0] len_q;
  logic [BW-1:0] sum_q;
  logic [LW-1:0] fill_q;
  logic [LW-1:0] rd_idx_q;
  logic [BW-1:0] mem [MAX_PAYLOAD];

  logic          out_valid_q;
  logic [BW-1:0] out_type_q;
  logic [LW-1:0] out_len_q;
  logic [LW-1:0] out_idx_q;
  logic [BW-1:0] out_data_q;
  logic          out_has_q;
  logic          out_last_q;

  logic          load;
  logic          len_zero_q;
  logic          rd_last;
  logic [LW:0]   fill_inc;
  logic [LW:0]   rd_inc;

  assign fill_inc   = {1'b0, fill_q} + 1'b1;
  assign rd_inc     = {1'b0, rd_idx_q} + 1'b1;
  assign len_zero_q = (len_q == '0);
  assign rd_last    = len_zero_q || (rd_inc == {1'b0, len_q});
  assign load       = cmd_i.emit && (!out_valid_q || res_ready_i);

  always_comb begin
    sts_o           = '0;
    sts_o.is_start  = (rx_byte_i == start_q);
    sts_o.len_zero  = (rx_byte_i == '0);
    sts_o.len_over  = (rx_byte_i > {{(BW-LW){1'b0}}, max_len_q})
                   || ({1'b0, rx_byte_i} > 9'(MAX_PAYLOAD));
    sts_o.body_done = (fill_inc >= {1'b0, len_q});
    sts_o.sum_match = (sum_q == rx_byte_i);
    sts_o.emit_done = load && rd_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= cfr_pkg::START_BYTE_RST;
      max_len_q <= cfr_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cfr_pkg::CFG_START_BYTE: start_q   <= cfg_data_i;
        cfr_pkg::CFG_MAX_LENGTH: max_len_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q   <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      fill_q   <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.cap_type) begin
        type_q <= rx_byte_i;
        sum_q  <= rx_byte_i;
      end
      if (cmd_i.cap_len) begin
        len_q  <= rx_byte_i[LW-1:0];
        sum_q  <= sum_q + rx_byte_i;
        fill_q <= '0;
      end
      if (cmd_i.wr_body) begin
        fill_q <= fill_inc[LW-1:0];
        sum_q  <= sum_q + rx_byte_i;
      end
      if (cmd_i.chk_sum) rd_idx_q <= '0;
      else if (load)     rd_idx_q <= rd_inc[LW-1:0];
    end
  end

  // payload store, body length never exceeds the depth
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_body) mem[AW'(fill_q)] <= rx_byte_i;
    if (load)          out_data_q       <= mem[AW'(rd_idx_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // header is copied so a new frame can start while the last result waits
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_type_q <= type_q;
      out_len_q  <= len_q;
      out_idx_q  <= rd_idx_q;
      out_has_q  <= !len_zero_q;
      out_last_q <= rd_last;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign frame_type_o    = out_type_q;
  assign frame_length_o  = out_len_q;
  assign byte_index_o    = out_idx_q[cfr_pkg::IDX_W-1:0];
  assign payload_byte_o  = out_has_q ? out_data_q : '0;
  assign has_payload_o   = out_has_q;
  assign last_of_frame_o = out_last_q;

  // last payload result sits at the end of the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_has_q && out_last_q)
      |-> ({1'b0, out_idx_q} + 1'b1 == {1'b0, out_len_q}))
    else $error("last flag off the frame end");

  // empty frame result is a single marked item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_has_q)
      |-> (out_last_q && out_idx_q == '0 && out_len_q == '0))
    else $error("malformed empty frame result");

endmodule
